[sv/sorted_ready_queue_core_defines.svh]
// assertion macros shared by the sorted ready queue rtl
// depends on nothing; included by files that carry assertions
`ifndef SORTED_READY_QUEUE_CORE_DEFINES_SVH
`define SORTED_READY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SRQ_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SRQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/srq_pkg.sv]
// sizes, command and status codes, and slot update struct for the sorted ready queue
// depends on nothing
package srq_pkg;

  localparam int DEPTH    = 32;
  localparam int ID_BITS  = 8;
  localparam int KEY_BITS = 16;
  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_POP    = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // one update of the slot array
  typedef struct packed {
    logic                ins;
    logic                drop;
    logic [IDX_BITS-1:0] pos;
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
  } slot_op_t;

endpackage

[sv/sorted_ready_queue_core.sv]
// Ready queue of up to 32 entries; sorted insert places by ascending key, append
// at the tail. A command word is taken when start is high and busy is low; its
// result word appears on the result ports for exactly one cycle with done high,
// and the receiver cannot stall it. A command keeps busy high through a scan
// state, which tries slot positions, the tail check included, and then an update
// state: sorted insert and remove-entry step a single shared comparator through
// the slots from the head, one slot a cycle, until a match or the tail; append,
// remove-front and insert into a full queue leave the scan state at once. The
// result strobe is high in the first cycle with busy low, which is also the first
// cycle in which a new command can be taken.
// depends on srq_pkg, srq_cmp, srq_slots and sorted_ready_queue_core_defines.svh
`include "sorted_ready_queue_core_defines.svh"

module sorted_ready_queue_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic [srq_pkg::ID_BITS-1:0]  entry_id,
  input  logic [srq_pkg::KEY_BITS-1:0] sort_key,
  output logic                         done,
  output logic [srq_pkg::ID_BITS-1:0]  popped_id,
  output logic                         popped_valid,
  output logic [1:0]                   status,
  output logic [5:0]                   occupancy
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  localparam logic [srq_pkg::CNT_BITS-1:0] FullCount = srq_pkg::CNT_BITS'(srq_pkg::DEPTH);

  state_t                       state, state_next;
  srq_pkg::cmd_t                cmd;
  logic [srq_pkg::ID_BITS-1:0]  id;
  logic [srq_pkg::KEY_BITS-1:0] key;
  logic [srq_pkg::CNT_BITS-1:0] idx;
  logic [srq_pkg::IDX_BITS-1:0] pos, pos_next;
  logic                         hit;
  logic [srq_pkg::CNT_BITS-1:0] count, count_next;

  logic                         accept;
  logic                         in_range;
  logic                         cmp_hit;
  logic                         scan_done;
  logic [srq_pkg::ID_BITS-1:0]  rd_id;
  logic [srq_pkg::KEY_BITS-1:0] rd_key;
  logic [srq_pkg::ID_BITS-1:0]  head_id;
  srq_pkg::slot_op_t            op;
  srq_pkg::status_t             status_next;
  logic [srq_pkg::ID_BITS-1:0]  popped_next;
  logic                         valid_next;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign in_range = (idx < count);

  // shared comparator against the slot under the scan pointer
  srq_cmp u_cmp (
    .by_id    (cmd == srq_pkg::CMD_REMOVE),
    .slot_id  (rd_id),
    .slot_key (rd_key),
    .id       (id),
    .key      (key),
    .hit      (cmp_hit)
  );

  srq_slots u_slots (
    .clk     (clk),
    .op      (op),
    .rd_idx  (idx[srq_pkg::IDX_BITS-1:0]),
    .rd_id   (rd_id),
    .rd_key  (rd_key),
    .head_id (head_id)
  );

  // scan ends at a match, at the tail, or at once for commands that need no search
  always_comb begin
    scan_done = 1'b1;
    pos_next  = idx[srq_pkg::IDX_BITS-1:0];
    unique case (cmd)
      srq_pkg::CMD_INSERT: begin
        scan_done = !in_range || cmp_hit || (count == FullCount);
      end
      srq_pkg::CMD_APPEND: begin
        pos_next = count[srq_pkg::IDX_BITS-1:0];
      end
      srq_pkg::CMD_POP: begin
        pos_next = '0;
      end
      srq_pkg::CMD_REMOVE: begin
        scan_done = !in_range || cmp_hit;
      end
      default: begin
        scan_done = 1'b1;
      end
    endcase
  end

  // update decision and result word
  always_comb begin
    op          = '0;
    op.pos      = pos;
    op.id       = id;
    op.key      = key;
    count_next  = count;
    status_next = srq_pkg::ST_OK;
    popped_next = '0;
    valid_next  = 1'b0;
    unique case (cmd)
      srq_pkg::CMD_INSERT, srq_pkg::CMD_APPEND: begin
        if (count == FullCount) begin
          status_next = srq_pkg::ST_FULL;
        end else begin
          op.ins     = (state == S_UPDATE);
          count_next = count + srq_pkg::CNT_BITS'(1);
        end
      end
      srq_pkg::CMD_POP: begin
        if (count == '0) begin
          status_next = srq_pkg::ST_EMPTY;
        end else begin
          op.drop     = (state == S_UPDATE);
          popped_next = head_id;
          valid_next  = 1'b1;
          count_next  = count - srq_pkg::CNT_BITS'(1);
        end
      end
      srq_pkg::CMD_REMOVE: begin
        if (hit) begin
          op.drop    = (state == S_UPDATE);
          count_next = count - srq_pkg::CNT_BITS'(1);
        end else begin
          status_next = srq_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        status_next = srq_pkg::ST_OK;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (scan_done) state_next = S_UPDATE;
      S_UPDATE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_UPDATE);
      if (state == S_UPDATE) begin
        count <= count_next;
      end
    end
  end

  // command word, scan pointer and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= srq_pkg::cmd_t'(command);
      id  <= entry_id;
      key <= sort_key;
      idx <= '0;
    end else if (state == S_SCAN) begin
      if (scan_done) begin
        pos <= pos_next;
        hit <= in_range && cmp_hit;
      end else begin
        idx <= idx + srq_pkg::CNT_BITS'(1);
      end
    end
    if (state == S_UPDATE) begin
      popped_id    <= popped_next;
      popped_valid <= valid_next;
      status       <= status_next;
      occupancy    <= 6'(count_next);
    end
  end

  // checks
  `SRQ_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "busy low after accepting a command")
  `SRQ_ASSERT_NOW(a_fall_done, clk, rst, $fell(busy), done, "command finished without a result")
  `SRQ_ASSERT_NOW(a_occ_count, clk, rst, done, occupancy == 6'(count),
    "reported occupancy differs from held count")
  `SRQ_ASSERT_NOW(a_occ_bound, clk, rst, 1'b1, count <= FullCount, "entry count above depth")
  `SRQ_ASSERT_NOW(a_pop_ok, clk, rst, done && popped_valid, status == srq_pkg::ST_OK,
    "popped entry reported with error status")

endmodule

[sv/srq_cmp.sv]
// shared compare unit: key greater-than for sorted insert, id match for remove
// depends on srq_pkg
module srq_cmp (
  input  logic                         by_id,
  input  logic [srq_pkg::ID_BITS-1:0]  slot_id,
  input  logic [srq_pkg::KEY_BITS-1:0] slot_key,
  input  logic [srq_pkg::ID_BITS-1:0]  id,
  input  logic [srq_pkg::KEY_BITS-1:0] key,
  output logic                         hit
);

  // strictly larger key keeps equal keys in arrival order
  always_comb begin
    if (by_id) begin
      hit = (slot_id == id);
    end else begin
      hit = (slot_key > key);
    end
  end

endmodule

[sv/srq_slots.sv]
// slot array in queue order, head at slot 0, with registered insert and drop shifts
// depends on srq_pkg
module srq_slots (
  input  logic                         clk,
  input  srq_pkg::slot_op_t            op,
  input  logic [srq_pkg::IDX_BITS-1:0] rd_idx,
  output logic [srq_pkg::ID_BITS-1:0]  rd_id,
  output logic [srq_pkg::KEY_BITS-1:0] rd_key,
  output logic [srq_pkg::ID_BITS-1:0]  head_id
);

  logic [srq_pkg::ID_BITS-1:0]  slot_ids  [srq_pkg::DEPTH];
  logic [srq_pkg::KEY_BITS-1:0] slot_keys [srq_pkg::DEPTH];

  // insert shifts slots past pos up from below; drop shifts slots from pos down
  for (genvar i = 0; i < srq_pkg::DEPTH; i++) begin : g_slot
    localparam logic [srq_pkg::IDX_BITS-1:0] SlotIdx = srq_pkg::IDX_BITS'(i);
    always_ff @(posedge clk) begin
      if (op.ins) begin
        if (SlotIdx == op.pos) begin
          slot_ids[i]  <= op.id;
          slot_keys[i] <= op.key;
        end else if (SlotIdx > op.pos) begin
          if (i > 0) begin
            slot_ids[i]  <= slot_ids[(i > 0) ? i - 1 : 0];
            slot_keys[i] <= slot_keys[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (op.drop) begin
        if (SlotIdx >= op.pos && i < srq_pkg::DEPTH - 1) begin
          slot_ids[i]  <= slot_ids[(i < srq_pkg::DEPTH - 1) ? i + 1 : i];
          slot_keys[i] <= slot_keys[(i < srq_pkg::DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // scan read port and head tap
  assign rd_id   = slot_ids[rd_idx];
  assign rd_key  = slot_keys[rd_idx];
  assign head_id = slot_ids[0];

endmodule

[tb/sv/tb.sv]
// self-checking testbench for sorted_ready_queue_core: directed table, then phased random words
// depends on srq_pkg and the sorted_ready_queue_core rtl
module tb;
  import srq_pkg::*;

  // one result word as the block reports it
  typedef struct {
    logic [ID_BITS-1:0] popped_id;
    logic               popped_valid;
    status_t            status;
    logic [5:0]         occupancy;
  } queue_result_t;

  // one row of the directed table
  typedef struct {
    cmd_t                op;
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
    bit                  typed;
    queue_result_t       want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          command;
  logic [ID_BITS-1:0]  entry_id;
  logic [KEY_BITS-1:0] sort_key;
  logic                done;
  logic [ID_BITS-1:0]  popped_id;
  logic                popped_valid;
  logic [1:0]          status;
  logic [5:0]          occupancy;

  // shadow copy of the queue contents, head at index 0
  logic [ID_BITS-1:0]  held_ids[$];
  logic [KEY_BITS-1:0] held_keys[$];

  queue_result_t pending_results[$];
  stim_row_t     steering[$];
  queue_result_t row_want;
  queue_result_t blank_result;
  bit            row_typed;
  int            words_sent;
  int            mismatches;

  sorted_ready_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .entry_id     (entry_id),
    .sort_key     (sort_key),
    .done         (done),
    .popped_id    (popped_id),
    .popped_valid (popped_valid),
    .status       (status),
    .occupancy    (occupancy)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // apply one command word to the shadow queue and return the result it must give
  function automatic queue_result_t apply_word(cmd_t op, logic [ID_BITS-1:0] id,
                                               logic [KEY_BITS-1:0] key);
    queue_result_t r;
    int slot;
    r.popped_id    = '0;
    r.popped_valid = 1'b0;
    r.status       = ST_OK;
    slot           = held_ids.size();
    case (op)
      CMD_INSERT, CMD_APPEND: begin
        if (held_ids.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // first strictly larger key from the head, so ties keep arrival order
          if (op == CMD_INSERT)
            for (int i = held_ids.size() - 1; i >= 0; i--)
              if (held_keys[i] > key) slot = i;
          if (slot == held_ids.size()) begin
            held_ids.push_back(id);
            held_keys.push_back(key);
          end else begin
            held_ids.insert(slot, id);
            held_keys.insert(slot, key);
          end
        end
      end
      CMD_POP: begin
        if (held_ids.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_id    = held_ids.pop_front();
          r.popped_valid = 1'b1;
          void'(held_keys.pop_front());
        end
      end
      default: begin
        // match nearest the head wins among duplicate ids
        slot = -1;
        for (int i = held_ids.size() - 1; i >= 0; i--)
          if (held_ids[i] == id) slot = i;
        if (slot < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          held_ids.delete(slot);
          held_keys.delete(slot);
        end
      end
    endcase
    r.occupancy = 6'(held_ids.size());
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (mismatches < 50)
      $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    mismatches++;
  endtask

  // check result words and record accepted command words
  always @(posedge clk) begin : result_check
    queue_result_t want;
    queue_result_t forecast;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (popped_id !== want.popped_id)
            report_mismatch("popped_id", int'(popped_id), int'(want.popped_id));
          if (popped_valid !== want.popped_valid)
            report_mismatch("popped_valid", int'(popped_valid), int'(want.popped_valid));
          if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
          if (occupancy !== want.occupancy)
            report_mismatch("occupancy", int'(occupancy), int'(want.occupancy));
        end
      end
      if (start && !busy) begin
        forecast = apply_word(cmd_t'(command), entry_id, sort_key);
        if (row_typed) pending_results.push_back(row_want);
        else pending_results.push_back(forecast);
      end
    end
  end

  // drive one word at the falling edge and hold it until the block takes it
  task automatic send_word(cmd_t op, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key,
                           bit typed, queue_result_t want);
    bit taken;
    int pause;
    taken = 1'b0;
    pause = 0;
    // no idling through a long middle stretch
    if ((words_sent < 350 || words_sent >= 600) && $urandom_range(99) < 24)
      pause = $urandom_range(1, 40);
    if (pause > 0) begin
      start <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    start     <= 1'b1;
    command   <= op;
    entry_id  <= id;
    sort_key  <= key;
    row_typed <= typed;
    row_want  <= want;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
    words_sent++;
  endtask

  task automatic issue(cmd_t op, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key);
    send_word(op, id, key, 1'b0, blank_result);
  endtask

  // hold off the sender until every result word is back
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic add_row(cmd_t op, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key,
                         bit typed, logic [ID_BITS-1:0] pid, logic pvalid,
                         status_t st, logic [5:0] occ);
    stim_row_t row;
    row.op                = op;
    row.id                = id;
    row.key               = key;
    row.typed             = typed;
    row.want.popped_id    = pid;
    row.want.popped_valid = pvalid;
    row.want.status       = st;
    row.want.occupancy    = occ;
    steering.push_back(row);
  endtask

  // small ranges make ties and duplicate ids common
  function automatic logic [ID_BITS-1:0] pick_id();
    if ($urandom_range(1) == 0) return ID_BITS'($urandom_range(15));
    return ID_BITS'($urandom_range((1 << ID_BITS) - 1));
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(3))
      0: return KEY_BITS'($urandom_range(7));
      1: return $urandom_range(1) ? '1 : '0;
      default: return KEY_BITS'($urandom_range((1 << KEY_BITS) - 1));
    endcase
  endfunction

  // mostly an id that is held, sometimes one that may be missing
  function automatic logic [ID_BITS-1:0] pick_victim();
    if (held_ids.size() > 0 && $urandom_range(9) < 8)
      return held_ids[$urandom_range(held_ids.size() - 1)];
    return pick_id();
  endfunction

  // fill to the top, then knock on the full queue
  task automatic run_fill();
    while (held_ids.size() < DEPTH)
      issue($urandom_range(99) < 75 ? CMD_INSERT : CMD_APPEND, pick_id(), pick_key());
    repeat ($urandom_range(1, 3))
      issue($urandom_range(1) ? CMD_INSERT : CMD_APPEND, pick_id(), pick_key());
  endtask

  // empty the queue by pops and removes, then hit the empty cases
  task automatic run_drain();
    while (held_ids.size() > 0)
      if ($urandom_range(1)) issue(CMD_POP, pick_id(), pick_key());
      else issue(CMD_REMOVE, pick_victim(), pick_key());
    issue(CMD_POP, pick_id(), pick_key());
    issue(CMD_REMOVE, pick_id(), pick_key());
  endtask

  task automatic run_mixed();
    int pick;
    repeat ($urandom_range(20, 60)) begin
      pick = $urandom_range(99);
      if (pick < 35) issue(CMD_INSERT, pick_id(), pick_key());
      else if (pick < 50) issue(CMD_APPEND, pick_id(), pick_key());
      else if (pick < 80) issue(CMD_POP, pick_id(), pick_key());
      else issue(CMD_REMOVE, pick_victim(), pick_key());
    end
  endtask

  initial begin
    int target;
    int kind;
    rst          = 1'b1;
    start        = 1'b0;
    command      = CMD_INSERT;
    entry_id     = '0;
    sort_key     = '0;
    row_typed    = 1'b0;
    words_sent   = 0;
    mismatches   = 0;
    blank_result.popped_id    = '0;
    blank_result.popped_valid = 1'b0;
    blank_result.status       = ST_OK;
    blank_result.occupancy    = '0;
    row_want     = blank_result;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: empty cases, extremes, ties, append out of order, duplicate ids
    add_row(CMD_POP,    8'h00, 16'h0000, 1, 8'h00, 1'b0, ST_EMPTY,    6'd0);
    add_row(CMD_REMOVE, 8'h00, 16'h0000, 1, 8'h00, 1'b0, ST_NOTFOUND, 6'd0);
    add_row(CMD_INSERT, 8'hFF, 16'hFFFF, 1, 8'h00, 1'b0, ST_OK,       6'd1);
    add_row(CMD_INSERT, 8'h00, 16'h0000, 1, 8'h00, 1'b0, ST_OK,       6'd2);
    add_row(CMD_APPEND, 8'h55, 16'h0000, 1, 8'h00, 1'b0, ST_OK,       6'd3);
    add_row(CMD_INSERT, 8'h10, 16'h0000, 0, 8'h00, 1'b0, ST_OK,       6'd0);
    add_row(CMD_INSERT, 8'h11, 16'h0001, 0, 8'h00, 1'b0, ST_OK,       6'd0);
    add_row(CMD_INSERT, 8'h10, 16'h8000, 0, 8'h00, 1'b0, ST_OK,       6'd0);
    add_row(CMD_REMOVE, 8'h10, 16'h0000, 0, 8'h00, 1'b0, ST_OK,       6'd0);
    add_row(CMD_REMOVE, 8'h77, 16'hFFFF, 1, 8'h00, 1'b0, ST_NOTFOUND, 6'd5);
    add_row(CMD_POP,    8'hFF, 16'hFFFF, 1, 8'h00, 1'b1, ST_OK,       6'd4);
    add_row(CMD_REMOVE, 8'hFF, 16'h0000, 0, 8'h00, 1'b0, ST_OK,       6'd0);
    add_row(CMD_APPEND, 8'hAA, 16'hFFFF, 0, 8'h00, 1'b0, ST_OK,       6'd0);
    add_row(CMD_INSERT, 8'h01, 16'hFFFF, 0, 8'h00, 1'b0, ST_OK,       6'd0);
    add_row(CMD_INSERT, 8'h22, 16'h0000, 0, 8'h00, 1'b0, ST_OK,       6'd0);
    repeat (6) add_row(CMD_POP, 8'h00, 16'h0000, 0, 8'h00, 1'b0, ST_OK, 6'd0);
    add_row(CMD_POP,    8'hFF, 16'hFFFF, 1, 8'h00, 1'b0, ST_EMPTY,    6'd0);
    foreach (steering[i])
      send_word(steering[i].op, steering[i].id, steering[i].key, steering[i].typed,
                steering[i].want);

    // random phases: full and empty reached first, then a mix
    target = words_sent + 900;
    run_fill();
    wait_drained();
    run_drain();
    while (words_sent < target) begin
      kind = $urandom_range(9);
      if (kind < 2) run_fill();
      else if (kind < 4) run_drain();
      else run_mixed();
      if ($urandom_range(4) == 0) wait_drained();
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * DEPTH) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
